[hdl/gpm_pkg.sv]
// ----------------------------------------------------------------------------
// gpm_pkg
// shared widths, stage counts and the tenth-root constant table
// ----------------------------------------------------------------------------
package gpm_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int FREQ_W    = 17;
    localparam int PHRED_W   = 14;
    localparam int PRIOR_W   = 31;
    localparam int MEAN_W    = 18;
    localparam int OUT_FRAC  = 16;
    localparam int QUOT_W    = OUT_FRAC + 3;
    localparam int WEIGHT_W  = 33;
    localparam int CONST_W   = 32;
    localparam logic [FREQ_W-1:0] FREQ_ONE = 17'd65536;
    localparam logic [63:0] TENTH_ROOT_Q32 = 64'd4233600378;
    localparam int LANE_LAT  = PHRED_W + 2;
    localparam int DIV_LAT   = QUOT_W + 1;

    // 10^(-2^b/160) in q0.32, squared with round half up from the first entry
    function automatic logic [CONST_W-1:0] gpm_root_const(input int b);
        logic [63:0] c;
        c = TENTH_ROOT_Q32;
        for (int i = 0; i < b; i++) begin
            c = (c * c + 64'h8000_0000) >> 32;
        end
        return c[CONST_W-1:0];
    endfunction

endpackage

[hdl/gpm_weight_lane.sv]
// ----------------------------------------------------------------------------
// gpm_weight_lane
// one genotype: weight 10^(-d/160) by one multiply per bit of d, then prior*w
// ----------------------------------------------------------------------------
module gpm_weight_lane import gpm_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_en,
    input  logic [PRIOR_W-1:0]                      i_prior,
    input  logic [PHRED_W-1:0]                      i_dist,
    output logic [PRIOR_W+FRACTION_BITS:0]          o_g
);
    localparam int SH = WEIGHT_W - 1 - FRACTION_BITS;
    localparam logic [WEIGHT_W:0] HALF =
        (SH == 0) ? '0 : ((WEIGHT_W+1)'(1) << ((SH > 0) ? SH - 1 : 0));

    logic [WEIGHT_W-1:0] r_w     [0:PHRED_W];
    logic [PHRED_W-1:0]  r_d     [0:PHRED_W];
    logic [PRIOR_W-1:0]  r_p     [0:PHRED_W];
    logic [FRACTION_BITS:0] r_wf;
    logic [PRIOR_W-1:0]  r_pf;
    logic [PRIOR_W+FRACTION_BITS:0] r_g;
    logic [WEIGHT_W:0]   n_wr;

    assign r_w[0] = WEIGHT_W'(64'h1_0000_0000);
    assign r_d[0] = i_dist;
    assign r_p[0] = i_prior;

    for (genvar b = 0; b < PHRED_W; b++) begin : g_step
        localparam logic [CONST_W-1:0] CB = gpm_root_const(b);
        logic [WEIGHT_W+CONST_W-1:0] n_prod;
        logic [WEIGHT_W-1:0] r_ws;
        logic [PHRED_W-1:0]  r_ds;
        logic [PRIOR_W-1:0]  r_ps;
        assign n_prod = r_w[b] * CB + (WEIGHT_W+CONST_W)'(64'h8000_0000);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ws <= r_d[b][b] ? n_prod[WEIGHT_W+CONST_W-1:CONST_W] : r_w[b];
                r_ds <= r_d[b];
                r_ps <= r_p[b];
            end
        end
        assign r_w[b+1] = r_ws;
        assign r_d[b+1] = r_ds;
        assign r_p[b+1] = r_ps;
    end

    // round q1.32 weight to the working fraction width
    assign n_wr = {1'b0, r_w[PHRED_W]} + HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wf <= n_wr[SH+FRACTION_BITS:SH];
            r_pf <= r_p[PHRED_W];
            r_g  <= r_pf * r_wf;
        end
    end

    assign o_g = r_g;
endmodule

[hdl/gpm_divider.sv]
// ----------------------------------------------------------------------------
// gpm_divider
// pipelined restoring division, one quotient bit a stage, then final rounding
// ----------------------------------------------------------------------------
module gpm_divider import gpm_pkg::*; #(
    parameter int SUM_W = 50
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [SUM_W-1:0]   i_num,
    input  logic [SUM_W-1:0]   i_sum,
    output logic [MEAN_W-1:0]  o_mean,
    output logic               o_zero
);
    logic [SUM_W:0]     r_rem  [0:QUOT_W];
    logic [SUM_W-1:0]   r_den  [0:QUOT_W];
    logic [QUOT_W-1:0]  r_q    [0:QUOT_W];
    logic               r_z    [0:QUOT_W];
    logic [MEAN_W-1:0]  r_mean;
    logic               r_zero;
    logic [QUOT_W:0]    n_rq;

    assign r_rem[0] = {1'b0, i_num};
    assign r_den[0] = i_sum;
    assign r_q[0]   = '0;
    assign r_z[0]   = (i_sum == '0);

    for (genvar j = 0; j < QUOT_W; j++) begin : g_bit
        logic [SUM_W+1:0] n_cur;
        logic [SUM_W+1:0] n_dv;
        logic             n_ge;
        logic [SUM_W+1:0] n_diff;
        logic [SUM_W:0]   r_rs;
        logic [SUM_W-1:0] r_ds;
        logic [QUOT_W-1:0] r_qs;
        logic             r_zs;
        // integer bits compare against 2*sum then sum, fraction bits shift the remainder
        if (j == 0) begin : g_two
            assign n_cur = {1'b0, r_rem[j]};
            assign n_dv  = {1'b0, r_den[j], 1'b0};
        end else if (j == 1) begin : g_one
            assign n_cur = {1'b0, r_rem[j]};
            assign n_dv  = {2'b00, r_den[j]};
        end else begin : g_frac
            assign n_cur = {r_rem[j], 1'b0};
            assign n_dv  = {2'b00, r_den[j]};
        end
        assign n_ge   = (n_cur >= n_dv);
        assign n_diff = n_ge ? (n_cur - n_dv) : n_cur;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rs <= n_diff[SUM_W:0];
                r_ds <= r_den[j];
                r_qs <= {r_q[j][QUOT_W-2:0], n_ge};
                r_zs <= r_z[j];
            end
        end
        assign r_rem[j+1] = r_rs;
        assign r_den[j+1] = r_ds;
        assign r_q[j+1]   = r_qs;
        assign r_z[j+1]   = r_zs;
    end

    assign n_rq = {1'b0, r_q[QUOT_W]} + (QUOT_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mean <= r_z[QUOT_W] ? '0 : n_rq[MEAN_W:1];
            r_zero <= r_z[QUOT_W];
        end
    end

    assign o_mean = r_mean;
    assign o_zero = r_zero;
endmodule

[hdl/genotype_posterior_mean.sv]
// path from input transfer to result: input register, weight lanes, merge register, divider
// throughput: one item per cycle unless the output stalls; three weight lanes and the divider are fully pipelined
// the whole pipeline advances together and holds while a result waits unaccepted
// reset (i_rst_n low, synchronous) clears all valid flags; payload is not reset
// the slave side is not ready while reset is held
// ----------------------------------------------------------------------------
// genotype_posterior_mean
// hardy-weinberg priors, phred weighting in three lanes, merge and divide
// ----------------------------------------------------------------------------
module genotype_posterior_mean import gpm_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // allele_freq[16:0], phred_hom_ref[30:17], phred_het[44:31], phred_hom_alt[58:45]
    input  logic [63:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // mean_genotype[17:0]
    output logic [23:0] o_m_tdata,
    // degenerate[0]
    output logic        o_m_tuser
);
    localparam int G_W = PRIOR_W + FRACTION_BITS + 1;
    localparam int S_W = G_W + 2;
    localparam int LAT = 1 + LANE_LAT + 1 + DIV_LAT;

    logic               n_en;
    logic [LAT-1:0]     r_vld;
    logic [FREQ_W-1:0]  n_p, n_q;
    logic [PHRED_W-1:0] n_ph [0:2];
    logic [PHRED_W-1:0] n_min;
    logic [2*FREQ_W-1:0] n_qq, n_pq, n_pp;
    logic [PRIOR_W-1:0] r_prior [0:2];
    logic [PHRED_W-1:0] r_dist  [0:2];
    logic [G_W-1:0]     n_g     [0:2];
    logic [S_W-1:0]     r_sum, r_num;
    logic [MEAN_W-1:0]  n_mean;
    logic               n_zero;

    assign n_en       = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = n_en && i_rst_n;

    assign n_p = (i_s_tdata[16:0] > FREQ_ONE) ? FREQ_ONE : i_s_tdata[16:0];
    assign n_q = FREQ_ONE - n_p;
    assign n_qq = n_q * n_q;
    assign n_pq = n_p * n_q;
    assign n_pp = n_p * n_p;
    assign n_ph[0] = i_s_tdata[30:17];
    assign n_ph[1] = i_s_tdata[44:31];
    assign n_ph[2] = i_s_tdata[58:45];

    always_comb begin
        n_min = n_ph[0];
        if (n_ph[1] < n_min) n_min = n_ph[1];
        if (n_ph[2] < n_min) n_min = n_ph[2];
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_prior[0] <= n_qq[PRIOR_W+1:2];
            r_prior[1] <= n_pq[PRIOR_W:1];
            r_prior[2] <= n_pp[PRIOR_W+1:2];
            for (int i = 0; i < 3; i++) begin
                r_dist[i] <= n_ph[i] - n_min;
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        gpm_weight_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane (
            .i_clk   (i_clk),
            .i_en    (n_en),
            .i_prior (r_prior[k]),
            .i_dist  (r_dist[k]),
            .o_g     (n_g[k])
        );
    end

    // merge the lanes
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_sum <= S_W'(n_g[0]) + S_W'(n_g[1]) + S_W'(n_g[2]);
            r_num <= S_W'(n_g[1]) + S_W'({n_g[2], 1'b0});
        end
    end

    gpm_divider #(.SUM_W(S_W)) u_div (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_num  (r_num),
        .i_sum  (r_sum),
        .o_mean (n_mean),
        .o_zero (n_zero)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    assign o_m_tvalid = r_vld[LAT-1];
    assign o_m_tdata  = {{(24-MEAN_W){1'b0}}, n_mean};
    assign o_m_tuser  = n_zero;

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> n_mean == '0)
        else $error("degenerate result with non-zero mean");
    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> n_mean <= MEAN_W'(131072))
        else $error("mean above two");
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_vld[0])
        else $error("accepted item not tracked");
endmodule
